>>> rtl/mssd_pkg.sv
// Package for the masked sum of squared differences block.
// Holds the pixel mode codes, the per-pixel contribution type and the
// squared-difference helper; no dependencies.
`timescale 1ns / 1ps

package mssd_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SQ_W     = 2 * CHAN_W;
	localparam int unsigned SQSUM_W  = SQ_W + 2;
	localparam int unsigned SUM_W    = 64;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned ADDCNT_W = 2;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [CHAN_W-1:0]   ALPHA_OPAQUE  = 8'd255;
	localparam logic [ADDCNT_W-1:0] GRAY_SAMPLES  = 2'd1;
	localparam logic [ADDCNT_W-1:0] COLOR_SAMPLES = 2'd3;

	localparam logic [0:0] REG_PIXEL_MODE = 1'b0;

	typedef enum logic [1:0] {
		MODE_GRAY = 2'd0,
		MODE_BGR  = 2'd1,
		MODE_BGRX = 2'd2,
		MODE_BGRA = 2'd3
	} pixel_mode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] tmpl_blue;
		logic [CHAN_W-1:0] tmpl_green;
		logic [CHAN_W-1:0] tmpl_red;
		logic [CHAN_W-1:0] tmpl_alpha;
		logic [CHAN_W-1:0] frame_blue;
		logic [CHAN_W-1:0] frame_green;
		logic [CHAN_W-1:0] frame_red;
		logic              last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [SQSUM_W-1:0]  sq_sum;
		logic [ADDCNT_W-1:0] count;
	} contrib_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
	endfunction

endpackage

>>> rtl/mssd_if.sv
// Stream interfaces for the masked sum of squared differences block:
// the pixel pair channel and the result channel.
// Depends on mssd_pkg for field widths.
`timescale 1ns / 1ps

interface mssd_pix_if
	import mssd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] tmpl_blue;
	logic [CHAN_W-1:0] tmpl_green;
	logic [CHAN_W-1:0] tmpl_red;
	logic [CHAN_W-1:0] tmpl_alpha;
	logic [CHAN_W-1:0] frame_blue;
	logic [CHAN_W-1:0] frame_green;
	logic [CHAN_W-1:0] frame_red;
	logic              last_pixel;

	modport source (output valid, tmpl_blue, tmpl_green, tmpl_red, tmpl_alpha,
		frame_blue, frame_green, frame_red, last_pixel, input ready);
	modport sink (input valid, tmpl_blue, tmpl_green, tmpl_red, tmpl_alpha,
		frame_blue, frame_green, frame_red, last_pixel, output ready);
endinterface

interface mssd_res_if
	import mssd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [SUM_W-1:0]   total_sqdiff;
	logic [COUNT_W-1:0] sample_count;

	modport source (output valid, total_sqdiff, sample_count, input ready);
	modport sink (input valid, total_sqdiff, sample_count, output ready);
endinterface

>>> rtl/mssd_pixel.sv
// Per-pixel contribution: squared channel differences and sample count
// under the current pixel mode, including the alpha mask.
// Depends on mssd_pkg.
`timescale 1ns / 1ps

module mssd_pixel
	import mssd_pkg::*;
(
	input  pixel_mode_t mode,
	input  pixel_t      pix,
	output contrib_t    contrib
);

	logic [SQ_W-1:0]    sq_b;
	logic [SQ_W-1:0]    sq_g;
	logic [SQ_W-1:0]    sq_r;
	logic [SQSUM_W-1:0] sq_all;

	assign sq_b   = sq_diff(pix.tmpl_blue, pix.frame_blue);
	assign sq_g   = sq_diff(pix.tmpl_green, pix.frame_green);
	assign sq_r   = sq_diff(pix.tmpl_red, pix.frame_red);
	assign sq_all = {2'b00, sq_b} + {2'b00, sq_g} + {2'b00, sq_r};

	always_comb begin
		contrib = '0;
		case (mode)
			MODE_GRAY: begin
				contrib.sq_sum = {2'b00, sq_b};
				contrib.count  = GRAY_SAMPLES;
			end
			MODE_BGR, MODE_BGRX: begin
				contrib.sq_sum = sq_all;
				contrib.count  = COLOR_SAMPLES;
			end
			MODE_BGRA: begin
				if (pix.tmpl_alpha == ALPHA_OPAQUE) begin
					contrib.sq_sum = sq_all;
					contrib.count  = COLOR_SAMPLES;
				end
			end
			default: contrib = '0;
		endcase
	end

endmodule

>>> rtl/masked_sum_squared_difference.sv
// Top level of the masked sum of squared differences block.
// Depends on mssd_pkg, mssd_if (mssd_pix_if, mssd_res_if) and mssd_pixel.
//
// Usage:
//   pix carries one template pixel and one frame pixel per item in raster
//   order; res carries one item (total_sqdiff, sample_count) for each
//   pixel marked last_pixel, after which both accumulators restart at zero.
//   The APB port holds pixel_mode at byte address 0; write it only while
//   no item is in flight. pready is always high.
// Timing:
//   One pixel is taken every cycle while no last pixel holds in the input
//   register. A pixel is registered at the input, its contribution is added
//   to the accumulators in the next cycle, and a last pixel's result passes
//   from the pixel register into the result register, then leaves on res.
// Reset and stall:
//   arst_n clears the mode to gray, the accumulators and all valid flags.
//   While res is stalled, non-last pixels keep streaming into the sums; a
//   second last pixel holds in the input register until res is taken.
`timescale 1ns / 1ps

module masked_sum_squared_difference
	import mssd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	mssd_pix_if.sink           pix,
	mssd_res_if.source         res
);

	pixel_mode_t        mode_q;
	logic               valid_s1;
	pixel_t             pix_s1;
	contrib_t           contrib;
	logic [SUM_W-1:0]   sum_acc_q;
	logic [COUNT_W-1:0] cnt_acc_q;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] cnt_next;
	logic               out_valid_q;
	logic [SUM_W-1:0]   out_sum_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic               out_free;
	logic               s1_go;
	logic               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRAY;
		end else if (cfg_write && paddr[PADDR_W-1] == REG_PIXEL_MODE) begin
			mode_q <= pixel_mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_PIXEL_MODE) begin
			prdata = {{(PDATA_W-2){1'b0}}, mode_q};
		end
	end

	assign out_free  = !out_valid_q || res.ready;
	assign s1_go     = valid_s1 && (!pix_s1.last_pixel || out_free);
	assign pix.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pix_s1 <= '{tmpl_blue: pix.tmpl_blue, tmpl_green: pix.tmpl_green,
				tmpl_red: pix.tmpl_red, tmpl_alpha: pix.tmpl_alpha,
				frame_blue: pix.frame_blue, frame_green: pix.frame_green,
				frame_red: pix.frame_red, last_pixel: pix.last_pixel};
		end
	end

	mssd_pixel u_pixel (
		.mode    (mode_q),
		.pix     (pix_s1),
		.contrib (contrib)
	);

	assign sum_next = sum_acc_q + {{(SUM_W-SQSUM_W){1'b0}}, contrib.sq_sum};
	assign cnt_next = cnt_acc_q + {{(COUNT_W-ADDCNT_W){1'b0}}, contrib.count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_acc_q <= '0;
			cnt_acc_q <= '0;
		end else if (s1_go) begin
			if (pix_s1.last_pixel) begin
				sum_acc_q <= '0;
				cnt_acc_q <= '0;
			end else begin
				sum_acc_q <= sum_next;
				cnt_acc_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && pix_s1.last_pixel) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && pix_s1.last_pixel) begin
			out_sum_q <= sum_next;
			out_cnt_q <= cnt_next;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.total_sqdiff = out_sum_q;
	assign res.sample_count = out_cnt_q;

`ifndef SYNTH
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && pix_s1.last_pixel) |=> (sum_acc_q == '0 && cnt_acc_q == '0))
		else $error("accumulators not cleared after last item");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(s1_go && pix_s1.last_pixel))
		else $error("result item without a last pixel");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (valid_s1 && pix_s1.last_pixel && res.valid && !res.ready))
		else $error("input stalled without a blocked result");
`endif

endmodule

>>> test/testbench.sv
// Testbench for masked_sum_squared_difference: APB mode setup, pixel stream
// stimulus with random idling and a receiver hold-off, and per-region checks.
// Depends on mssd_pkg, mssd_if and the block's top level.
`timescale 1ns / 1ps

module testbench;
	import mssd_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_PIXEL_MODE = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_SPARE      = 3'd4;
	localparam int N_PROBES = 22;

	typedef struct packed {
		logic [SUM_W-1:0]   total;
		logic [COUNT_W-1:0] count;
	} region_result_t;

	typedef struct packed {
		pixel_mode_t        mode;
		logic [CHAN_W-1:0]  tb, tg, tr, ta;
		logic [CHAN_W-1:0]  fb, fg, fr;
		logic               last;
		logic               typed;
		logic [SUM_W-1:0]   total;
		logic [COUNT_W-1:0] count;
	} probe_row_t;

	probe_row_t probe_rows [N_PROBES] = '{
		'{MODE_GRAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 64'd0, 32'd1},
		'{MODE_GRAY, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1,
			64'd65025, 32'd1},
		'{MODE_GRAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
			64'd65025, 32'd1},
		'{MODE_GRAY, 8'd10, 8'd200, 8'd3, 8'd7, 8'd20, 8'd1, 8'd99, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_GRAY, 8'd77, 8'd0, 8'd255, 8'd0, 8'd66, 8'd255, 8'd0, 1'b1, 1'b0, 64'd0, 32'd0},
		'{MODE_BGR, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1,
			64'd195075, 32'd3},
		'{MODE_BGR, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
			64'd195075, 32'd3},
		'{MODE_BGR, 8'd12, 8'd34, 8'd56, 8'd78, 8'd90, 8'd12, 8'd34, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_BGR, 8'd200, 8'd100, 8'd50, 8'd25, 8'd100, 8'd200, 8'd25, 1'b1, 1'b0,
			64'd0, 32'd0},
		'{MODE_BGRX, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1,
			64'd195075, 32'd3},
		'{MODE_BGRX, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_BGRX, 8'd128, 8'd128, 8'd128, 8'd128, 8'd127, 8'd129, 8'd128, 1'b1, 1'b0,
			64'd0, 32'd0},
		'{MODE_BGRA, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1,
			64'd195075, 32'd3},
		'{MODE_BGRA, 8'd255, 8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1,
			64'd0, 32'd0},
		'{MODE_BGRA, 8'd9, 8'd9, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_BGRA, 8'd1, 8'd1, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_BGRA, 8'd40, 8'd50, 8'd60, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 64'd0, 32'd0},
		'{MODE_BGRA, 8'd30, 8'd20, 8'd10, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_GRAY, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_BGR, 8'd1, 8'd2, 8'd3, 8'd0, 8'd4, 8'd5, 8'd6, 1'b1, 1'b0, 64'd0, 32'd0},
		'{MODE_GRAY, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
		'{MODE_GRAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1, 1'b1,
			64'd130050, 32'd2}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	mssd_pix_if pix_bus ();
	mssd_res_if res_bus ();

	masked_sum_squared_difference dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_bus),
		.res     (res_bus)
	);

	pixel_mode_t        cfg_mode;
	logic [SUM_W-1:0]   region_sum;
	logic [COUNT_W-1:0] region_count;
	region_result_t     pending_results [$];
	int                 mismatches;
	int                 src_idle_pct;
	int                 snk_stall_pct;
	int                 res_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [SUM_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [SUM_W-1:0] d;
		d = (a >= b) ? SUM_W'(a - b) : SUM_W'(b - a);
		return d * d;
	endfunction

	// Fold one pixel into the region sums; return 1 with the result on a last pixel.
	function automatic bit accumulate_pixel(input pixel_t p, output region_result_t r);
		logic [SUM_W-1:0]   add_sum;
		logic [COUNT_W-1:0] add_count;
		logic [SUM_W-1:0]   color_sum;
		color_sum = chan_sq(p.tmpl_blue, p.frame_blue) + chan_sq(p.tmpl_green, p.frame_green)
			+ chan_sq(p.tmpl_red, p.frame_red);
		add_sum = '0;
		add_count = '0;
		case (cfg_mode)
			MODE_GRAY: begin
				add_sum = chan_sq(p.tmpl_blue, p.frame_blue);
				add_count = COUNT_W'(GRAY_SAMPLES);
			end
			MODE_BGR, MODE_BGRX: begin
				add_sum = color_sum;
				add_count = COUNT_W'(COLOR_SAMPLES);
			end
			default: begin
				if (p.tmpl_alpha == ALPHA_OPAQUE) begin
					add_sum = color_sum;
					add_count = COUNT_W'(COLOR_SAMPLES);
				end
			end
		endcase
		region_sum = region_sum + add_sum;
		region_count = region_count + add_count;
		r.total = region_sum;
		r.count = region_count;
		if (!p.last_pixel)
			return 1'b0;
		region_sum = '0;
		region_count = '0;
		return 1'b1;
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return CHAN_W'($urandom_range(255));
		endcase
	endfunction

	// Write one register, then read back pixel_mode in a back-to-back transfer.
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ADDR_PIXEL_MODE)
			cfg_mode = pixel_mode_t'(data[1:0]);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_PIXEL_MODE;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== PDATA_W'(cfg_mode)) begin
			$display("%0t: pixel_mode read expected %0d, got %0d", $time, cfg_mode, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_pixel(input pixel_t p, input bit typed, input region_result_t typed_res);
		region_result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.tmpl_blue <= p.tmpl_blue;
		pix_bus.tmpl_green <= p.tmpl_green;
		pix_bus.tmpl_red <= p.tmpl_red;
		pix_bus.tmpl_alpha <= p.tmpl_alpha;
		pix_bus.frame_blue <= p.frame_blue;
		pix_bus.frame_green <= p.frame_green;
		pix_bus.frame_red <= p.frame_red;
		pix_bus.last_pixel <= p.last_pixel;
		@(posedge clk);
		while (!pix_bus.ready) @(posedge clk);
		if (accumulate_pixel(p, r))
			pending_results.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		pix_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (res_hold > 0) begin
			res_bus.ready <= 1'b0;
			res_hold = res_hold - 1;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		region_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item, total_sqdiff %0d sample_count %0d", $time,
					res_bus.total_sqdiff, res_bus.sample_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (res_bus.total_sqdiff !== want.total) begin
					$display("%0t: total_sqdiff expected %0d, got %0d", $time, want.total,
						res_bus.total_sqdiff);
					mismatches++;
				end
				if (res_bus.sample_count !== want.count) begin
					$display("%0t: sample_count expected %0d, got %0d", $time, want.count,
						res_bus.sample_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		pixel_t         p;
		region_result_t typed_res;
		probe_row_t     row;
		int             left;
		int             style;
		pixel_mode_t    mode;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_bus.valid = 1'b0;
		pix_bus.tmpl_blue = '0;
		pix_bus.tmpl_green = '0;
		pix_bus.tmpl_red = '0;
		pix_bus.tmpl_alpha = '0;
		pix_bus.frame_blue = '0;
		pix_bus.frame_green = '0;
		pix_bus.frame_red = '0;
		pix_bus.last_pixel = 1'b0;
		res_bus.ready = 1'b0;
		cfg_mode = MODE_GRAY;
		region_sum = '0;
		region_count = '0;
		mismatches = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		res_hold = 0;
		left = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// spare address must leave the mode at gray
		write_reg(ADDR_SPARE, 32'h0000_0003);

		for (int i = 0; i < N_PROBES; i++) begin
			row = probe_rows[i];
			if (row.mode != cfg_mode) begin
				drain_results();
				write_reg(ADDR_PIXEL_MODE, PDATA_W'(row.mode));
			end
			p.tmpl_blue = row.tb;
			p.tmpl_green = row.tg;
			p.tmpl_red = row.tr;
			p.tmpl_alpha = row.ta;
			p.frame_blue = row.fb;
			p.frame_green = row.fg;
			p.frame_red = row.fr;
			p.last_pixel = row.last;
			typed_res.total = row.total;
			typed_res.count = row.count;
			send_pixel(p, row.typed, typed_res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			src_idle_pct = 0;
			snk_stall_pct = 0;
			style = (ph < 4) ? ph : ((ph == 4) ? 0 : $urandom_range(3));
			case (style)
				1: src_idle_pct = 87;
				2: snk_stall_pct = 87;
				3: begin
					src_idle_pct = 36;
					snk_stall_pct = 36;
				end
				default: ;
			endcase
			case (ph)
				0: mode = MODE_BGRA;
				1: mode = MODE_GRAY;
				2: mode = MODE_BGR;
				3: mode = MODE_BGRX;
				4: mode = MODE_BGRA;
				default: mode = pixel_mode_t'($urandom_range(3));
			endcase
			if ($urandom_range(3) == 0)
				write_reg(ADDR_SPARE, $urandom);
			write_reg(ADDR_PIXEL_MODE, ($urandom & ~32'h3) | PDATA_W'(mode));
			// hold the result side off while pixels keep coming
			if (ph == 4)
				res_hold = 400;
			for (int n = 0; n < 125; n++) begin
				if (left == 0)
					left = ($urandom_range(15) == 0) ? $urandom_range(120, 40)
						: $urandom_range(16, 1);
				p.tmpl_blue = rand_chan();
				p.tmpl_green = rand_chan();
				p.tmpl_red = rand_chan();
				p.tmpl_alpha = (cfg_mode == MODE_BGRA && $urandom_range(9) < 6)
					? ALPHA_OPAQUE : rand_chan();
				p.frame_blue = rand_chan();
				p.frame_green = rand_chan();
				p.frame_red = rand_chan();
				p.last_pixel = (left == 1);
				left--;
				send_pixel(p, 1'b0, typed_res);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/mssd_pkg.sv
rtl/mssd_if.sv
rtl/mssd_pixel.sv
rtl/masked_sum_squared_difference.sv
test/testbench.sv
